[src/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define TTPR_ASSERT_IMP(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("ttpr: property failed");

// next-cycle implication, off during reset
`define TTPR_ASSERT_NXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("ttpr: property failed");

// next-cycle implication, live through reset
`define TTPR_ASSERT_RST(lbl, ck, a, c) \
  lbl: assert property (@(posedge ck) (a) |=> (c)) \
    else $error("ttpr: property failed");

`endif

[src/ttpr_pkg.sv]
// Types and constants shared by the tunnel renderer modules.
package ttpr_pkg;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_FILL, ST_HREAD, ST_HWR1, ST_HWR2, ST_PHASE, ST_MISC,
    ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_MUL5, ST_CINIT, ST_CORDIC,
    ST_SCALE, ST_ROUND, ST_DIV, ST_ADDR, ST_SHADE
  } ttpr_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_CLR_FB, OP_FILL, OP_HREAD, OP_HWR1, OP_HWR2, OP_PHASE,
    OP_MUL0, OP_MUL1, OP_MUL2, OP_MUL3, OP_MUL4, OP_MUL5, OP_CINIT, OP_CORDIC,
    OP_SCALE, OP_ROUND, OP_DIV, OP_ADDR, OP_SHADE
  } ttpr_op_t;

  typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC, CNT_DEC} ttpr_cnt_op_t;

  typedef struct packed {
    ttpr_op_t     op;
    ttpr_cnt_op_t cnt_op;
    logic         emit;
  } ttpr_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic fill_last;
    logic hash_last;
    logic cordic_last;
    logic div_last;
  } ttpr_status_t;

  localparam logic [1:0] CMD_TEXTURE = 2'd0;
  localparam logic [1:0] CMD_FRAME   = 2'd1;
  localparam logic [1:0] CMD_RENDER  = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  localparam logic [1:0] REG_COS = 2'd0;
  localparam logic [1:0] REG_SIN = 2'd1;

  localparam logic signed [15:0] COS_RESET = 16'sd32767;
  localparam logic signed [15:0] SIN_RESET = 16'sd0;
  localparam logic [7:0] PHASE_RESET = 8'hFF;
  localparam logic [7:0] PHASE_STEP  = 8'd8;
  localparam logic [7:0] TEX_SEED    = 8'hC9;
  localparam logic [15:0] TEX_MIRROR = 16'hFF00;
  localparam logic [15:0] TEX_LAG    = 16'd255;
  localparam logic [7:0] SHADE_NEAR  = 8'hFB;
  localparam logic [7:0] SHADE_MID   = 8'hF0;
  localparam logic [7:0] SHADE_FAR   = 8'hD0;
  localparam int EYE    = 160;
  localparam int TSCALE = 41;

  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;

  localparam logic [29:0] ATAN_Q30 [24] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };

endpackage

[src/ttpr_ctrl.sv]
// Sequencer for the tunnel renderer: issues one datapath operation per cycle.
module ttpr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0]            command,
  input  ttpr_pkg::ttpr_status_t status,
  output ttpr_pkg::ttpr_cmd_t    cmd,
  output logic                  busy
);

  ttpr_pkg::ttpr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttpr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ttpr_pkg::ST_CLEAR:  if (status.clear_last) state_next = ttpr_pkg::ST_IDLE;
      ttpr_pkg::ST_IDLE: begin
        if (start) begin
          unique case (command)
            ttpr_pkg::CMD_TEXTURE: state_next = ttpr_pkg::ST_FILL;
            ttpr_pkg::CMD_FRAME:   state_next = ttpr_pkg::ST_PHASE;
            ttpr_pkg::CMD_RENDER:  state_next = ttpr_pkg::ST_MUL0;
            default:               state_next = ttpr_pkg::ST_MISC;
          endcase
        end
      end
      ttpr_pkg::ST_FILL:   if (status.fill_last) state_next = ttpr_pkg::ST_HREAD;
      ttpr_pkg::ST_HREAD:  state_next = ttpr_pkg::ST_HWR1;
      ttpr_pkg::ST_HWR1:   state_next = ttpr_pkg::ST_HWR2;
      ttpr_pkg::ST_HWR2: begin
        state_next = status.hash_last ? ttpr_pkg::ST_IDLE : ttpr_pkg::ST_HREAD;
      end
      ttpr_pkg::ST_PHASE:  state_next = ttpr_pkg::ST_IDLE;
      ttpr_pkg::ST_MISC:   state_next = ttpr_pkg::ST_IDLE;
      ttpr_pkg::ST_MUL0:   state_next = ttpr_pkg::ST_MUL1;
      ttpr_pkg::ST_MUL1:   state_next = ttpr_pkg::ST_MUL2;
      ttpr_pkg::ST_MUL2:   state_next = ttpr_pkg::ST_MUL3;
      ttpr_pkg::ST_MUL3:   state_next = ttpr_pkg::ST_MUL4;
      ttpr_pkg::ST_MUL4:   state_next = ttpr_pkg::ST_MUL5;
      ttpr_pkg::ST_MUL5:   state_next = ttpr_pkg::ST_CINIT;
      ttpr_pkg::ST_CINIT:  state_next = ttpr_pkg::ST_CORDIC;
      ttpr_pkg::ST_CORDIC: if (status.cordic_last) state_next = ttpr_pkg::ST_SCALE;
      ttpr_pkg::ST_SCALE:  state_next = ttpr_pkg::ST_ROUND;
      ttpr_pkg::ST_ROUND:  state_next = ttpr_pkg::ST_DIV;
      ttpr_pkg::ST_DIV:    if (status.div_last) state_next = ttpr_pkg::ST_ADDR;
      ttpr_pkg::ST_ADDR:   state_next = ttpr_pkg::ST_SHADE;
      ttpr_pkg::ST_SHADE:  state_next = ttpr_pkg::ST_IDLE;
      default:             state_next = ttpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op     = ttpr_pkg::OP_NONE;
    cmd.cnt_op = ttpr_pkg::CNT_HOLD;
    cmd.emit   = 1'b0;
    unique case (state)
      ttpr_pkg::ST_CLEAR: begin
        cmd.op     = ttpr_pkg::OP_CLR_FB;
        cmd.cnt_op = ttpr_pkg::CNT_INC;
      end
      ttpr_pkg::ST_IDLE: begin
        if (start) begin
          cmd.op     = ttpr_pkg::OP_LATCH;
          cmd.cnt_op = ttpr_pkg::CNT_CLR;
        end
      end
      ttpr_pkg::ST_FILL: begin
        cmd.op     = ttpr_pkg::OP_FILL;
        cmd.cnt_op = status.fill_last ? ttpr_pkg::CNT_CLR : ttpr_pkg::CNT_INC;
      end
      ttpr_pkg::ST_HREAD: cmd.op = ttpr_pkg::OP_HREAD;
      ttpr_pkg::ST_HWR1:  cmd.op = ttpr_pkg::OP_HWR1;
      ttpr_pkg::ST_HWR2: begin
        cmd.op     = ttpr_pkg::OP_HWR2;
        cmd.cnt_op = ttpr_pkg::CNT_DEC;
        cmd.emit   = status.hash_last;
      end
      ttpr_pkg::ST_PHASE: begin
        cmd.op   = ttpr_pkg::OP_PHASE;
        cmd.emit = 1'b1;
      end
      ttpr_pkg::ST_MISC:  cmd.emit = 1'b1;
      ttpr_pkg::ST_MUL0:  cmd.op = ttpr_pkg::OP_MUL0;
      ttpr_pkg::ST_MUL1:  cmd.op = ttpr_pkg::OP_MUL1;
      ttpr_pkg::ST_MUL2:  cmd.op = ttpr_pkg::OP_MUL2;
      ttpr_pkg::ST_MUL3:  cmd.op = ttpr_pkg::OP_MUL3;
      ttpr_pkg::ST_MUL4:  cmd.op = ttpr_pkg::OP_MUL4;
      ttpr_pkg::ST_MUL5:  cmd.op = ttpr_pkg::OP_MUL5;
      ttpr_pkg::ST_CINIT: begin
        cmd.op     = ttpr_pkg::OP_CINIT;
        cmd.cnt_op = ttpr_pkg::CNT_CLR;
      end
      ttpr_pkg::ST_CORDIC: begin
        cmd.op     = ttpr_pkg::OP_CORDIC;
        cmd.cnt_op = ttpr_pkg::CNT_INC;
      end
      ttpr_pkg::ST_SCALE: cmd.op = ttpr_pkg::OP_SCALE;
      ttpr_pkg::ST_ROUND: begin
        cmd.op     = ttpr_pkg::OP_ROUND;
        cmd.cnt_op = ttpr_pkg::CNT_CLR;
      end
      ttpr_pkg::ST_DIV: begin
        cmd.op     = ttpr_pkg::OP_DIV;
        cmd.cnt_op = ttpr_pkg::CNT_INC;
      end
      ttpr_pkg::ST_ADDR:  cmd.op = ttpr_pkg::OP_ADDR;
      ttpr_pkg::ST_SHADE: begin
        cmd.op   = ttpr_pkg::OP_SHADE;
        cmd.emit = 1'b1;
      end
      default: cmd.op = ttpr_pkg::OP_NONE;
    endcase
  end

  assign busy = (state != ttpr_pkg::ST_IDLE);

endmodule

[src/ttpr_datapath.sv]
// Datapath: texture and feedback memories, multiplier, CORDIC, divider, shading.
module ttpr_datapath #(
  parameter int VIEW_ROWS    = 160,
  parameter int VIEW_WIDTH   = 320,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ttpr_pkg::ttpr_cmd_t     cmd,
  output ttpr_pkg::ttpr_status_t  status,
  input  logic [1:0]             command,
  input  logic signed [7:0]      pixel_row,
  input  logic signed [8:0]      pixel_col,
  input  logic                   cfg_valid,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  output logic                   done,
  output logic [1:0]             done_kind,
  output logic [7:0]             pixel_value
);

  localparam int FB_DEPTH = VIEW_ROWS * VIEW_WIDTH;
  localparam int FB_AW    = $clog2(FB_DEPTH);
  localparam int CNT_W    = (FB_AW > 16) ? FB_AW : 16;
  localparam int PROD_W   = 58;
  localparam int AW       = 35;
  localparam int BW       = 31;
  localparam int YW       = 26;
  localparam int PW       = 27;
  localparam int XW       = 38;
  localparam int ZW       = 35;
  localparam int DIV_W    = 41;
  localparam int RW       = 38;

  function automatic longint cordic_ref(input int steps);
    longint vx, vy, dx, dy;
    int i;
    vx = 64'sd1 <<< 23;
    vy = 64'sd0;
    for (i = 0; i < steps; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy > 0) begin
        vx = vx + dx;
        vy = vy - dy;
      end else begin
        vx = vx - dx;
        vy = vy + dy;
      end
    end
    return vx;
  endfunction

  localparam longint KREF = longint'(ttpr_pkg::TSCALE) * cordic_ref(CORDIC_STEPS);

  logic [7:0] tex_mem [65536];
  logic [7:0] fb_mem  [FB_DEPTH];

  logic signed [15:0] cos_q, sin_q;
  logic [7:0]  phase;
  logic [1:0]  cmd_q;
  logic signed [7:0] row_q;
  logic signed [8:0] col_q;
  logic [CNT_W-1:0] cnt;
  logic [15:0] hash;
  logic [7:0]  acc;
  logic signed [PROD_W-1:0] prod, num;
  logic signed [YW-1:0] t1, y1, z1;
  logic signed [PW-1:0] p, q;
  logic signed [XW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic        zero_v, tvneg, magpos;
  logic [7:0]  tu;
  logic [DIV_W-1:0] dvd;
  logic [RW-1:0] rem;
  logic [7:0]  shade_base;
  logic [7:0]  tex_q, fb_q;

  logic [15:0] idx;
  assign idx = cnt[15:0];

  always_comb begin
    status.clear_last  = (cnt == CNT_W'(FB_DEPTH - 1));
    status.fill_last   = (idx == 16'hFFFF);
    status.hash_last   = (idx == 16'd1);
    status.cordic_last = (cnt == CNT_W'(CORDIC_STEPS - 1));
    status.div_last    = (cnt == CNT_W'(DIV_W - 1));
  end

  // shared multiplier
  logic signed [AW-1:0] opa;
  logic signed [BW-1:0] opb;
  logic signed [AW+BW-1:0] full;
  always_comb begin
    unique case (cmd.op)
      ttpr_pkg::OP_MUL0:   begin opa = AW'(col_q); opb = BW'(cos_q); end
      ttpr_pkg::OP_MUL1:   begin opa = AW'(row_q); opb = BW'(sin_q); end
      ttpr_pkg::OP_MUL2:   begin opa = AW'(row_q); opb = BW'(cos_q); end
      ttpr_pkg::OP_MUL3:   begin opa = AW'(col_q); opb = BW'(sin_q); end
      ttpr_pkg::OP_MUL4:   begin opa = AW'(y1);    opb = BW'(cos_q); end
      ttpr_pkg::OP_MUL5:   begin opa = AW'(y1);    opb = BW'(sin_q); end
      ttpr_pkg::OP_CORDIC: begin opa = AW'(q);     opb = BW'(KREF);  end
      ttpr_pkg::OP_SCALE:  begin opa = AW'(z);     opb = BW'(ttpr_pkg::TSCALE); end
      default:             begin opa = '0;         opb = '0;         end
    endcase
  end
  assign full = opa * opb;

  // eye terms and projection
  logic signed [PROD_W-1:0] eye_sn, eye_co, psum, qsum;
  assign eye_sn = (PROD_W'(sin_q) * PROD_W'(ttpr_pkg::EYE)) <<< 15;
  assign eye_co = (PROD_W'(cos_q) * PROD_W'(ttpr_pkg::EYE)) <<< 15;
  assign psum = prod + eye_sn;
  assign qsum = eye_co - prod;

  // CORDIC
  logic signed [XW-1:0] x0, y0, dxs, dys;
  logic signed [ZW-1:0] at;
  logic [4:0] sh;
  assign x0  = XW'(z1) <<< 8;
  assign y0  = XW'(p) <<< 8;
  assign sh  = cnt[4:0];
  assign dxs = y >>> sh;
  assign dys = x >>> sh;
  assign at  = $signed(ZW'(ttpr_pkg::ATAN_Q30[sh]));

  // rounding and divider set-up
  logic [PROD_W-1:0] tmag, nmag;
  logic [PROD_W-1:0] tround;
  logic [PROD_W:0]   nsum;
  assign tmag   = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign tround = (tmag + (PROD_W'(1) << 29)) >> 30;
  assign nmag   = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
  assign nsum   = {nmag, 1'b0} + ((PROD_W + 1)'(x[XW-2:0]) << 15);

  logic [RW-1:0] rem_sh;
  logic          qbit;
  assign rem_sh = {rem[RW-2:0], dvd[DIV_W-1]};
  assign qbit   = (rem_sh >= {1'b0, x[XW-2:0]});

  // texel address and shade band
  logic [7:0]  tu8, tv8, band;
  logic [15:0] ofs, uv, uv2, uvf, a1, a2;
  logic [8:0]  bsum;
  logic [7:0]  bdif;
  always_comb begin
    tu8  = zero_v ? 8'd0 : tu;
    tv8  = (zero_v || !magpos) ? 8'd0 : (tvneg ? 8'(-dvd[7:0]) : dvd[7:0]);
    uv   = {tv8, tu8};
    ofs  = {phase, 8'h01};
    a1   = ofs + uv;
    bsum = {1'b0, a1[7:0]} + {1'b0, a1[15:8]};
    uv2  = uv << 2;
    a2   = ofs + uv2;
    bdif = a2[7:0] - a2[15:8];
    if (bsum[6]) begin
      if (bdif[7]) begin
        uvf  = uv2 << 1;
        band = ttpr_pkg::SHADE_FAR;
      end else begin
        uvf  = uv2;
        band = ttpr_pkg::SHADE_MID;
      end
    end else begin
      uvf  = uv;
      band = ttpr_pkg::SHADE_NEAR;
    end
  end

  // feedback buffer address
  logic signed [10:0] rr, cc;
  logic        in_view;
  logic [FB_AW:0] kf;
  logic [FB_AW-1:0] k;
  assign rr = 11'(row_q) + 11'(VIEW_ROWS / 2);
  assign cc = 11'(col_q) + 11'(VIEW_WIDTH / 2);
  assign in_view = (rr >= 0) && (rr < 11'(VIEW_ROWS)) && (cc >= 0) && (cc < 11'(VIEW_WIDTH));
  assign kf = (FB_AW + 1)'(rr[8:0]) * (FB_AW + 1)'(VIEW_WIDTH) + (FB_AW + 1)'(cc[9:0]);
  assign k  = kf[FB_AW-1:0];

  // texture hash step
  logic [15:0] hsum, hrot;
  logic [7:0]  hi, anew;
  logic [8:0]  r1, r2;
  assign hsum = hash + idx;
  always_comb begin
    logic [31:0] dbl;
    dbl  = {hsum, hsum} << idx[3:0];
    hrot = dbl[31:16];
  end
  assign hi   = 8'($signed(hash[7:0]) >>> 5);
  assign r1   = {1'b0, acc} + {1'b0, hi} + 9'(hash[4]);
  assign r2   = {1'b0, r1[7:0]} + {1'b0, tex_q} + 9'(r1[8]);
  assign anew = {1'b0, r2[7:1]};

  // shading
  logic [7:0] shade, vsum, fb_new;
  assign shade  = shade_base + tex_q;
  assign vsum   = fb_q + shade;
  assign fb_new = 8'($signed(vsum) >>> 2);

  // memory ports
  logic        tex_we, tex_re, fb_we, fb_re;
  logic [15:0] tex_waddr, tex_raddr;
  logic [7:0]  tex_wdata, fb_wdata;
  logic [FB_AW-1:0] fb_addr;
  always_comb begin
    tex_we    = 1'b0;
    tex_waddr = idx;
    tex_wdata = idx[7:0];
    tex_re    = 1'b0;
    tex_raddr = idx + ttpr_pkg::TEX_LAG;
    fb_we     = 1'b0;
    fb_re     = 1'b0;
    fb_addr   = k;
    fb_wdata  = fb_new;
    unique case (cmd.op)
      ttpr_pkg::OP_CLR_FB: begin
        fb_we    = 1'b1;
        fb_addr  = cnt[FB_AW-1:0];
        fb_wdata = 8'd0;
      end
      ttpr_pkg::OP_FILL:  tex_we = 1'b1;
      ttpr_pkg::OP_HREAD: tex_re = 1'b1;
      ttpr_pkg::OP_HWR1: begin
        tex_we    = 1'b1;
        tex_wdata = anew;
      end
      ttpr_pkg::OP_HWR2: begin
        tex_we    = 1'b1;
        tex_waddr = idx ^ ttpr_pkg::TEX_MIRROR;
        tex_wdata = acc;
      end
      ttpr_pkg::OP_ADDR: begin
        tex_re    = 1'b1;
        tex_raddr = ofs + uvf;
        fb_re     = 1'b1;
      end
      ttpr_pkg::OP_SHADE: fb_we = in_view;
      default: tex_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tex_we) tex_mem[tex_waddr] <= tex_wdata;
    if (tex_re) tex_q <= tex_mem[tex_raddr];
  end

  always_ff @(posedge clk) begin
    if (fb_we) fb_mem[fb_addr] <= fb_wdata;
    if (fb_re) fb_q <= fb_mem[fb_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      done  <= 1'b0;
      phase <= ttpr_pkg::PHASE_RESET;
      cos_q <= ttpr_pkg::COS_RESET;
      sin_q <= ttpr_pkg::SIN_RESET;
    end else begin
      unique case (cmd.cnt_op)
        ttpr_pkg::CNT_CLR: cnt <= '0;
        ttpr_pkg::CNT_INC: cnt <= cnt + 1'b1;
        ttpr_pkg::CNT_DEC: cnt <= cnt - 1'b1;
        default:           cnt <= cnt;
      endcase
      done <= cmd.emit;
      if (cmd.op == ttpr_pkg::OP_PHASE) phase <= phase + ttpr_pkg::PHASE_STEP;
      if (cfg_valid && cfg_index == ttpr_pkg::REG_COS) cos_q <= cfg_data;
      if (cfg_valid && cfg_index == ttpr_pkg::REG_SIN) sin_q <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      done_kind   <= cmd_q;
      pixel_value <= (cmd.op == ttpr_pkg::OP_SHADE) ? (in_view ? vsum : shade) : 8'd0;
    end
    unique case (cmd.op)
      ttpr_pkg::OP_LATCH: begin
        cmd_q <= command;
        row_q <= pixel_row;
        col_q <= pixel_col;
        hash  <= 16'd0;
        acc   <= ttpr_pkg::TEX_SEED;
      end
      ttpr_pkg::OP_HREAD: hash <= hrot;
      ttpr_pkg::OP_HWR1:  acc <= anew;
      ttpr_pkg::OP_MUL0:  prod <= full[PROD_W-1:0];
      ttpr_pkg::OP_MUL1: begin
        t1   <= prod[YW-1:0];
        prod <= full[PROD_W-1:0];
      end
      ttpr_pkg::OP_MUL2: begin
        y1   <= t1 + prod[YW-1:0];
        prod <= full[PROD_W-1:0];
      end
      ttpr_pkg::OP_MUL3: begin
        t1   <= prod[YW-1:0];
        prod <= full[PROD_W-1:0];
      end
      ttpr_pkg::OP_MUL4: begin
        z1   <= t1 - prod[YW-1:0];
        prod <= full[PROD_W-1:0];
      end
      ttpr_pkg::OP_MUL5: begin
        p    <= psum[PW+14:15];
        prod <= full[PROD_W-1:0];
      end
      ttpr_pkg::OP_CINIT: begin
        q      <= qsum[PW+14:15];
        zero_v <= (p == '0) && (z1 == '0);
        if (x0 < 0) begin
          x <= -x0;
          y <= -y0;
          z <= (y0 >= 0) ? ZW'(ttpr_pkg::PI_Q30) : ZW'(-ttpr_pkg::PI_Q30);
        end else begin
          x <= x0;
          y <= y0;
          z <= '0;
        end
      end
      ttpr_pkg::OP_CORDIC: begin
        prod <= full[PROD_W-1:0];
        if (y > 0) begin
          x <= x + dxs;
          y <= y - dys;
          z <= z + at;
        end else begin
          x <= x - dxs;
          y <= y + dys;
          z <= z - at;
        end
      end
      ttpr_pkg::OP_SCALE: begin
        num  <= prod;
        prod <= full[PROD_W-1:0];
      end
      ttpr_pkg::OP_ROUND: begin
        tu     <= prod[PROD_W-1] ? 8'(-tround[7:0]) : tround[7:0];
        tvneg  <= num[PROD_W-1];
        magpos <= (x > 0);
        dvd    <= nsum[DIV_W+15:16];
        rem    <= '0;
      end
      ttpr_pkg::OP_DIV: begin
        rem <= qbit ? (rem_sh - {1'b0, x[XW-2:0]}) : rem_sh;
        dvd <= {dvd[DIV_W-2:0], qbit};
      end
      ttpr_pkg::OP_ADDR: shade_base <= band;
      default: shade_base <= shade_base;
    endcase
  end

endmodule

[src/tube_tunnel_pixel_renderer_unit.sv]
// Top level of the tube tunnel pixel renderer.
// Render: multiply, CORDIC, scale, round, divide, address, shade, then the result strobe.
// Start frame and unknown commands: the PHASE or MISC state issues the result strobe.
// Texture build: a fill pass, then one read and two writes per texel on the one write port.
// One command at a time, busy until the result beat is issued; results are never held off.
// Reset clears all VIEW_ROWS*VIEW_WIDTH feedback buffer entries, one entry a cycle.
module tube_tunnel_pixel_renderer_unit #(
  parameter int VIEW_ROWS    = 160,
  parameter int VIEW_WIDTH   = 320,
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic signed [7:0] pixel_row,
  input  logic signed [8:0] pixel_col,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              done,
  output logic [1:0]        done_kind,
  output logic [7:0]        pixel_value
);

  ttpr_pkg::ttpr_cmd_t    cmd;
  ttpr_pkg::ttpr_status_t status;

  assign cfg_ready = 1'b1;

  ttpr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  ttpr_datapath #(
    .VIEW_ROWS    (VIEW_ROWS),
    .VIEW_WIDTH   (VIEW_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .command     (command),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .done_kind   (done_kind),
    .pixel_value (pixel_value)
  );

endmodule

[src/ttpr_checker.sv]
// Port-level checker for the tunnel renderer, bound to the top level.
`include "assert_macros.svh"

module ttpr_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] done_kind,
  input logic [7:0] pixel_value
);

  logic other_done;
  assign other_done = done && (done_kind != ttpr_pkg::CMD_RENDER);

  `TTPR_ASSERT_RST(a_reset_sweep, clk, rst, busy)
  `TTPR_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `TTPR_ASSERT_NXT(a_done_single, clk, rst, done, !done)
  `TTPR_ASSERT_IMP(a_pix_zero, clk, rst, other_done, pixel_value == 8'd0)

endmodule

bind tube_tunnel_pixel_renderer_unit ttpr_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .done_kind   (done_kind),
  .pixel_value (pixel_value)
);
